// File: hw/rtl/lps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg
// types and opcodes shared by the linear prime sieve
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam logic [1:0] OP_REBUILD = 2'd0;
    localparam logic [1:0] OP_TEST    = 2'd1;
    localparam logic [1:0] OP_INDEX   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] operand;
    } lps_in_t;

    typedef struct packed {
        logic [15:0] value;
        logic        is_prime;
        logic        error;
    } lps_out_t;

endpackage

// File: hw/rtl/linear_prime_sieve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_prime_sieve
// linear sieve with rebuild, primality test and k-th prime queries
// ----------------------------------------------------------------------------
// test or index query: the request passes S_QRD and S_QOUT, done rises
// with the result, and a new item is taken only once back in S_IDLE
// a rebuild clears both mark stores, then checks each candidate and runs its
// marking steps (table read, multiply, mark, remainder check), the
// remainder check taking one bit a cycle; busy stays high throughout
// reset clears count and built flag and sets limit to 65535; done pulses, no stall
// ----------------------------------------------------------------------------
module linear_prime_sieve #(
    parameter int MAX_VALUE   = 65536,
    parameter int PRIME_SLOTS = 8192
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                start,
    input  lps_pkg::lps_in_t    in_item,
    output logic                busy,
    output logic                done,
    output lps_pkg::lps_out_t   out_item
);
    import lps_pkg::*;

    localparam int VW = $clog2(MAX_VALUE);
    localparam int SW = $clog2(PRIME_SLOTS);
    localparam int CW = SW + 1;
    // widths used to compare 16-bit operands against store sizes
    localparam int XW = (VW > 16 ? VW : 16) + 1;
    localparam int YW = (CW > 16 ? CW : 16) + 1;
    localparam int BW = $clog2(XW);
    localparam logic [XW-1:0] MAX_TOP = XW'(MAX_VALUE - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_QRD, S_QOUT, S_CLR, S_CAND, S_CHK, S_PRD, S_MUL, S_MARK,
        S_DIV, S_DONE
    } state_t;

    // stores: marks and prime table
    logic              pmark_mem [MAX_VALUE];
    logic              cmark_mem [MAX_VALUE];
    logic [VW-1:0]     ptab_mem  [PRIME_SLOTS];

    state_t            state_reg;
    logic [15:0]       limit_reg;
    logic              built_reg;
    logic [XW-1:0]     top_reg;
    logic [CW-1:0]     count_reg;
    lps_in_t           req_reg;
    logic [XW-1:0]     i_reg;
    logic [CW-1:0]     j_reg;
    logic [VW-1:0]     p_reg;
    logic [2*XW-1:0]   prod_reg;
    logic [XW-1:0]     rem_reg;
    logic [BW-1:0]     bit_reg;
    logic [VW-1:0]     addr_reg;
    logic              done_reg;
    lps_out_t          res_reg;

    // registered read ports
    logic              pmark_rd;
    logic              cmark_rd;
    logic [VW-1:0]     ptab_rd;

    // memory write/read controls
    logic              pm_we, cm_we, pt_we;
    logic              pm_wd, cm_wd;
    logic [VW-1:0]     pm_wa, cm_wa, m_ra;
    logic [SW-1:0]     pt_wa, pt_ra;
    logic [VW-1:0]     pt_wd;

    always_comb
    begin
        pm_we = 1'b0;
        cm_we = 1'b0;
        pt_we = 1'b0;
        pm_wd = 1'b0;
        cm_wd = 1'b0;
        pm_wa = addr_reg;
        cm_wa = addr_reg;
        pt_wa = count_reg[SW-1:0];
        pt_wd = i_reg[VW-1:0];
        m_ra  = i_reg[VW-1:0];
        pt_ra = j_reg[SW-1:0];
        unique case (state_reg)
            S_CLR:
            begin
                pm_we = 1'b1;
                cm_we = 1'b1;
            end
            S_CHK:
            begin
                // new prime found and the table has room
                if (!cmark_rd && count_reg < CW'(PRIME_SLOTS))
                begin
                    pm_we = 1'b1;
                    pm_wd = 1'b1;
                    pm_wa = i_reg[VW-1:0];
                    pt_we = 1'b1;
                end
            end
            S_MARK:
            begin
                if (prod_reg <= (2*XW)'(top_reg))
                begin
                    cm_we = 1'b1;
                    cm_wd = 1'b1;
                    cm_wa = prod_reg[VW-1:0];
                end
            end
            S_IDLE, S_QRD:
            begin
                m_ra  = VW'(req_reg.operand);
                pt_ra = SW'(req_reg.operand);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
            pmark_mem[pm_wa] <= pm_wd;
        if (cm_we)
            cmark_mem[cm_wa] <= cm_wd;
        if (pt_we)
            ptab_mem[pt_wa] <= pt_wd;
        pmark_rd <= pmark_mem[m_ra];
        cmark_rd <= cmark_mem[m_ra];
        ptab_rd  <= ptab_mem[pt_ra];
    end

    // saturated sieve top from the limit
    logic [XW-1:0] lim_top;
    assign lim_top = (XW'(limit_reg) > MAX_TOP) ? MAX_TOP : XW'(limit_reg);

    logic [XW-1:0] op_x;
    logic [YW-1:0] op_y;
    assign op_x = XW'(req_reg.operand);
    assign op_y = YW'(req_reg.operand);

    // one restoring remainder step: shift in the next bit of i, subtract p
    logic [XW-1:0] rem_sh;
    logic [XW-1:0] rem_next;
    assign rem_sh   = {rem_reg[XW-2:0], i_reg[bit_reg]};
    assign rem_next = (rem_sh >= XW'(p_reg)) ? rem_sh - XW'(p_reg) : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= 16'hFFFF;
            built_reg <= 1'b0;
            count_reg <= '0;
            top_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_QOUT) || (state_reg == S_DONE);
            if (cfg_we)
                limit_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= in_item;
                        if (in_item.opcode == OP_REBUILD)
                        begin
                            state_reg <= S_CLR;
                            addr_reg  <= '0;
                            top_reg   <= lim_top;
                            count_reg <= '0;
                        end
                        else
                            state_reg <= S_QRD;
                    end
                end
                S_QRD:
                    // read address held, data valid next cycle
                    state_reg <= S_QOUT;
                S_QOUT:
                begin
                    unique case (req_reg.opcode)
                        OP_TEST:
                        begin
                            if (!built_reg || op_x > top_reg)
                                res_reg <= '{value: 16'd0, is_prime: 1'b0,
                                             error: 1'b1};
                            else
                                res_reg <= '{value: 16'd0, is_prime: pmark_rd,
                                             error: 1'b0};
                        end
                        OP_INDEX:
                        begin
                            if (!built_reg || op_y >= YW'(count_reg))
                                res_reg <= '{value: 16'd0, is_prime: 1'b0,
                                             error: 1'b1};
                            else
                                res_reg <= '{value: 16'(ptab_rd), is_prime: 1'b0,
                                             error: 1'b0};
                        end
                        default:
                            res_reg <= '{value: 16'd0, is_prime: 1'b0, error: 1'b1};
                    endcase
                    state_reg <= S_IDLE;
                end
                S_CLR:
                begin
                    // clearing sweep over both mark stores
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == VW'(MAX_VALUE - 1))
                    begin
                        i_reg     <= XW'(2);
                        state_reg <= S_CAND;
                    end
                end
                S_CAND:
                begin
                    if (i_reg > top_reg)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    j_reg <= '0;
                    if (!cmark_rd)
                    begin
                        if (count_reg >= CW'(PRIME_SLOTS))
                        begin
                            // table full: the sieve stops below this prime
                            top_reg   <= i_reg - 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                            state_reg <= S_PRD;
                        end
                    end
                    else
                        state_reg <= S_PRD;
                end
                S_PRD:
                begin
                    // table read for prime j issued, data next cycle
                    if (j_reg >= count_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_CAND;
                    end
                    else
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    p_reg     <= ptab_rd;
                    prod_reg  <= (2*XW)'(ptab_rd) * (2*XW)'(i_reg);
                    state_reg <= S_MARK;
                end
                S_MARK:
                begin
                    if (prod_reg > (2*XW)'(top_reg))
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_CAND;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        bit_reg   <= BW'(XW - 1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // i mod p, one bit of i a cycle from the top
                    rem_reg <= rem_next;
                    if (bit_reg == '0)
                    begin
                        if (rem_next == '0)
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_CAND;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_PRD;
                        end
                    end
                    else
                        bit_reg <= bit_reg - 1'b1;
                end
                S_DONE:
                begin
                    built_reg <= 1'b1;
                    res_reg   <= '{value: 16'(count_reg), is_prime: 1'b0,
                                   error: 1'b0};
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign out_item = res_reg;

endmodule
